// File: sv/ttv_pkg.sv
package ttv_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int TEX_WIDTH = 16;

	// edge and texcoord deltas carry one bit of growth
	localparam int DIFF_W = ((COORD_WIDTH > TEX_WIDTH) ? COORD_WIDTH : TEX_WIDTH) + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int MAG_W = PROD_W + 1;
	localparam int A_W = 30;
	localparam int NORM_W = (MAG_W > A_W + 1) ? MAG_W : A_W + 1;
	localparam int SUM_W = 2 * A_W + 2;
	localparam int BIT_W = SUM_W - 1;
	localparam int ROOT_W = A_W + 1;
	localparam int FRAC = 14;
	localparam int Q_W = FRAC + 1;
	localparam int NUM_W = A_W + FRAC + 1;
	localparam int SH_W = $clog2(Q_W);
	localparam int OUT_W = 16;
	localparam int N_OPS = 7;
	localparam int K_W = $clog2(N_OPS);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		diff_t [2:0] s0;
		diff_t [2:0] s1;
		diff_t du0;
		diff_t du1;
		diff_t dv0;
		diff_t dv1;
	} tri_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		PH_V0,
		PH_V1,
		PH_V2
	} phase_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_NORM,
		B_SQ,
		B_SQRT,
		B_DLOAD,
		B_DIV,
		B_OUT
	} bstate_t;

	// product pairs: normal x, y, z, tangent x, y, z, uv determinant
	localparam logic [K_W-1:0] K_NX = K_W'(0);
	localparam logic [K_W-1:0] K_NY = K_W'(1);
	localparam logic [K_W-1:0] K_NZ = K_W'(2);
	localparam logic [K_W-1:0] K_TX = K_W'(3);
	localparam logic [K_W-1:0] K_TY = K_W'(4);
	localparam logic [K_W-1:0] K_TZ = K_W'(5);
	localparam logic [K_W-1:0] K_DET = K_W'(6);

endpackage

// File: sv/ttv_front.sv
module ttv_front import ttv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [TEX_WIDTH-1:0] tex_u,
	input  logic signed [TEX_WIDTH-1:0] tex_v,
	input  qstat_t qstat,
	output logic push,
	output tri_t item
);

	phase_t phase_q;
	phase_t phase_nxt;
	logic signed [COORD_WIDTH-1:0] pa_q [3];
	logic signed [COORD_WIDTH-1:0] pb_q [3];
	logic signed [COORD_WIDTH-1:0] pin [3];
	logic signed [TEX_WIDTH-1:0] ua_q, va_q, ub_q, vb_q;
	logic acc;

	assign pin[0] = pos_x;
	assign pin[1] = pos_y;
	assign pin[2] = pos_z;

	// third vertex needs a free queue slot, the first two only get stored
	assign in_ready = (phase_q != PH_V2) || !qstat.full;
	assign acc = in_valid && in_ready;
	assign push = acc && (phase_q == PH_V2);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			item.s0[i] = DIFF_W'(pa_q[i]) - DIFF_W'(pb_q[i]);
			item.s1[i] = DIFF_W'(pin[i]) - DIFF_W'(pa_q[i]);
		end
		item.du0 = DIFF_W'(ua_q) - DIFF_W'(ub_q);
		item.du1 = DIFF_W'(tex_u) - DIFF_W'(ua_q);
		item.dv0 = DIFF_W'(va_q) - DIFF_W'(vb_q);
		item.dv1 = DIFF_W'(tex_v) - DIFF_W'(va_q);
	end

	always_comb begin
		unique case (phase_q)
			PH_V0: phase_nxt = PH_V1;
			PH_V1: phase_nxt = PH_V2;
			PH_V2: phase_nxt = PH_V0;
			default: phase_nxt = PH_V1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_V0;
		end else if (acc) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_V1) begin
			for (int i = 0; i < 3; i++) pb_q[i] <= pin[i];
			ub_q <= tex_u;
			vb_q <= tex_v;
		end else if (acc && phase_q != PH_V2) begin
			for (int i = 0; i < 3; i++) pa_q[i] <= pin[i];
			ua_q <= tex_u;
			va_q <= tex_v;
		end
	end

endmodule

// File: sv/ttv_queue.sv
module ttv_queue import ttv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tri_t wr_item,
	input  logic pop,
	output tri_t rd_item,
	output qstat_t qstat
);

	tri_t mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign rd_item = mem_q[rp_q];
	assign qstat.full = (cnt_q == CNT_W'(Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PTR_W'(1);
			if (pop) rp_q <= rp_q + PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end

endmodule

// File: sv/ttv_back.sv
module ttv_back import ttv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  qstat_t qstat,
	input  tri_t item,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OUT_W-1:0] tan_x,
	output logic signed [OUT_W-1:0] tan_y,
	output logic signed [OUT_W-1:0] tan_z,
	output logic mirrored,
	output logic degenerate
);

	function automatic logic [OUT_W-1:0] apply_sign(logic [Q_W-1:0] q, logic ng);
		logic [OUT_W-1:0] v;
		v = OUT_W'(q);
		return ng ? (OUT_W'(0) - v) : v;
	endfunction

	bstate_t st_q, st_nxt;
	logic [K_W-1:0] k_q;
	logic [1:0] j_q;
	logic [SH_W-1:0] sh_q;
	logic ov_q;

	tri_t op_q;
	logic nz_q, det_neg_q, degen_q;
	logic tneg_q [3];
	logic [NORM_W-1:0] nm_q [3];
	logic [SUM_W-1:0] acc_q, res_q;
	logic [BIT_W-1:0] bit_q;
	logic [NUM_W-1:0] rem_q;
	logic [Q_W-1:0] qacc_q;
	logic [Q_W-1:0] quo_q [3];

	logic signed [DIFF_W-1:0] ma, mb, mc, md;
	logic signed [PROD_W-1:0] pab, pcd;
	logic signed [PROD_W:0] dp;
	logic [MAG_W-1:0] dmag;
	logic [NORM_W-1:0] nor_all;
	logic norm_hi, norm_ok;
	logic [A_W-1:0] asel;
	logic [2*A_W-1:0] sq;
	logic [SUM_W-1:0] strial;
	logic sge;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0] dtrial;
	logic dge;
	logic [Q_W-1:0] qnext;
	logic out_load, mir;

	// operand pairs for a*b - c*d
	always_comb begin
		unique case (k_q)
			K_NX: begin ma = op_q.s1[1]; mb = op_q.s0[2]; mc = op_q.s1[2]; md = op_q.s0[1]; end
			K_NY: begin ma = op_q.s1[2]; mb = op_q.s0[0]; mc = op_q.s1[0]; md = op_q.s0[2]; end
			K_NZ: begin ma = op_q.s1[0]; mb = op_q.s0[1]; mc = op_q.s1[1]; md = op_q.s0[0]; end
			K_TX: begin ma = op_q.dv1; mb = op_q.s0[0]; mc = op_q.dv0; md = op_q.s1[0]; end
			K_TY: begin ma = op_q.dv1; mb = op_q.s0[1]; mc = op_q.dv0; md = op_q.s1[1]; end
			K_TZ: begin ma = op_q.dv1; mb = op_q.s0[2]; mc = op_q.dv0; md = op_q.s1[2]; end
			default: begin ma = op_q.dv1; mb = op_q.du0; mc = op_q.dv0; md = op_q.du1; end
		endcase
	end

	assign pab = ma * mb;
	assign pcd = mc * md;
	assign dp = $signed({pab[PROD_W-1], pab}) - $signed({pcd[PROD_W-1], pcd});
	assign dmag = dp[PROD_W] ? MAG_W'(-dp) : MAG_W'(dp);

	assign nor_all = nm_q[0] | nm_q[1] | nm_q[2];
	assign norm_hi = |nor_all[NORM_W-1:A_W];
	assign norm_ok = !norm_hi && nor_all[A_W-1];

	always_comb begin
		unique case (j_q)
			2'd0: asel = nm_q[0][A_W-1:0];
			2'd1: asel = nm_q[1][A_W-1:0];
			default: asel = nm_q[2][A_W-1:0];
		endcase
	end

	assign sq = asel * asel;
	assign strial = res_q + SUM_W'(bit_q);
	assign sge = acc_q >= strial;

	assign root = res_q[ROOT_W-1:0];
	assign dtrial = NUM_W'(root) << sh_q;
	assign dge = rem_q >= dtrial;
	assign qnext = qacc_q | (Q_W'(dge) << sh_q);

	assign mir = nz_q && det_neg_q;

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			B_IDLE: if (!qstat.empty) st_nxt = B_MUL;
			B_MUL: if (k_q == K_DET) st_nxt = B_NORM;
			B_NORM: begin
				if (nor_all == '0) st_nxt = B_OUT;
				else if (norm_ok) st_nxt = B_SQ;
			end
			B_SQ: if (j_q == 2'd2) st_nxt = B_SQRT;
			B_SQRT: if (bit_q[0]) st_nxt = B_DLOAD;
			B_DLOAD: st_nxt = B_DIV;
			B_DIV: begin
				if (sh_q == '0) st_nxt = (j_q == 2'd2) ? B_OUT : B_DLOAD;
			end
			B_OUT: if (!ov_q || out_ready) st_nxt = B_IDLE;
			default: st_nxt = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			B_IDLE: pop = !qstat.empty;
			B_OUT: out_load = !ov_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ov_q <= 1'b0;
			k_q <= '0;
			j_q <= '0;
			sh_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				B_IDLE: k_q <= '0;
				B_MUL: k_q <= k_q + K_W'(1);
				B_NORM: j_q <= '0;
				B_SQ: j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
				B_DLOAD: sh_q <= SH_W'(Q_W - 1);
				B_DIV: begin
					sh_q <= sh_q - SH_W'(1);
					if (sh_q == '0) j_q <= j_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				op_q <= item;
				nz_q <= 1'b0;
			end
			B_MUL: begin
				unique case (k_q)
					K_NX, K_NY, K_NZ: nz_q <= nz_q | (dp != '0);
					K_TX: begin nm_q[0] <= NORM_W'(dmag); tneg_q[0] <= dp[PROD_W]; end
					K_TY: begin nm_q[1] <= NORM_W'(dmag); tneg_q[1] <= dp[PROD_W]; end
					K_TZ: begin nm_q[2] <= NORM_W'(dmag); tneg_q[2] <= dp[PROD_W]; end
					default: det_neg_q <= dp[PROD_W];
				endcase
			end
			B_NORM: begin
				degen_q <= (nor_all == '0);
				acc_q <= '0;
				if (nor_all != '0 && !norm_ok) begin
					for (int i = 0; i < 3; i++) begin
						nm_q[i] <= norm_hi ? (nm_q[i] >> 1) : (nm_q[i] << 1);
					end
				end
			end
			B_SQ: begin
				acc_q <= acc_q + SUM_W'(sq);
				res_q <= '0;
				bit_q <= {1'b1, {(BIT_W-1){1'b0}}};
			end
			B_SQRT: begin
				if (sge) begin
					acc_q <= acc_q - strial;
					res_q <= (res_q >> 1) + SUM_W'(bit_q);
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_DLOAD: begin
				rem_q <= (NUM_W'(asel) << FRAC) + NUM_W'(root >> 1);
				qacc_q <= '0;
			end
			B_DIV: begin
				if (dge) rem_q <= rem_q - dtrial;
				qacc_q <= qnext;
				if (sh_q == '0) begin
					unique case (j_q)
						2'd0: quo_q[0] <= qnext;
						2'd1: quo_q[1] <= qnext;
						default: quo_q[2] <= qnext;
					endcase
				end
			end
			B_OUT: begin
				if (out_load) begin
					if (degen_q) begin
						tan_x <= '0;
						tan_y <= '0;
						tan_z <= '0;
						mirrored <= 1'b0;
						degenerate <= 1'b1;
					end else begin
						tan_x <= apply_sign(quo_q[0], tneg_q[0] != mir);
						tan_y <= apply_sign(quo_q[1], tneg_q[1] != mir);
						tan_z <= apply_sign(quo_q[2], tneg_q[2] != mir);
						mirrored <= mir;
						degenerate <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;

endmodule

// File: sv/triangle_tangent_vector.sv
// order of work after the third vertex request: pop, product pairs, normalize, sum of squares,
// square-root steps, per component a load and divide steps, output load; a zero tangent skips to output load
// the back-end sequencer works on one triangle at a time and pops the next after loading the result;
// vertices one and two are always accepted, and output stalls hold the sequencer in its output state
// a two-entry queue lets the next triangle's vertices arrive while the back end works
// reset: arst_n async active low clears phase, queue pointers, sequencer and output valid
module triangle_tangent_vector import ttv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [TEX_WIDTH-1:0] tex_u,
	input  logic signed [TEX_WIDTH-1:0] tex_v,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OUT_W-1:0] tan_x,
	output logic signed [OUT_W-1:0] tan_y,
	output logic signed [OUT_W-1:0] tan_z,
	output logic mirrored,
	output logic degenerate
);

	// front to queue: triangle deltas, pushed on the third vertex request
	logic q_push;
	tri_t q_wr_item;
	// queue to back
	logic q_pop;
	tri_t q_rd_item;
	qstat_t q_stat;

	// front: stores vertices one and two, forms edge and uv deltas
	ttv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.qstat    (q_stat),
		.push     (q_push),
		.item     (q_wr_item)
	);

	// decoupling queue between front and back
	ttv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.qstat   (q_stat)
	);

	// back: products, normalize, sum of squares, square root, divide, sign fixup, output register
	ttv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (q_stat),
		.item       (q_rd_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tan_x      (tan_x),
		.tan_y      (tan_y),
		.tan_z      (tan_z),
		.mirrored   (mirrored),
		.degenerate (degenerate)
	);

`ifndef SYNTHESIS
	// a zero tangent comes out as all zeros, never mirrored
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tan_x == 0 && tan_y == 0 && tan_z == 0 && !mirrored)
		else $error("degenerate result with nonzero tangent");

	// unit tangent components stay within one in Q1.14
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> tan_x >= -16384 && tan_x <= 16384 &&
			tan_y >= -16384 && tan_y <= 16384 && tan_z >= -16384 && tan_z <= 16384)
		else $error("tangent component out of range");

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue overflow");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue underflow");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ttv_pkg::*;

	// one vertex request as seen on the input channel
	typedef struct {
		logic signed [COORD_WIDTH-1:0] px, py, pz;
		logic signed [TEX_WIDTH-1:0] tu, tv;
	} vertex_t;

	// one tangent result as seen on the output channel
	typedef struct {
		logic [OUT_W-1:0] tx, ty, tz;
		logic mir, degen;
	} tangent_t;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int LONG_HOLD = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_WIDTH-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [TEX_WIDTH-1:0] tex_u = '0, tex_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] tan_x, tan_y, tan_z;
	logic mirrored, degenerate;

	// pending vertices and expected tangents
	vertex_t vertex_fifo[$];
	tangent_t tangent_fifo[$];

	// idle rates in percent, set per phase
	int send_idle = 7;
	int recv_idle = 85;
	int errors = 0;
	int cycles = 0;
	bit stop_send = 1'b0;
	bit hold_request = 1'b0;
	bit hold_started = 1'b0;
	int hold_left = 0;

	// predictor state: vertices held for the current triangle
	int vtx_count = 0;
	longint held_pos[6];
	longint held_tex[4];

	always #5 clk = ~clk;

	triangle_tangent_vector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z),
		.mirrored(mirrored), .degenerate(degenerate)
	);

	// integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic int bit_length(longint unsigned x);
		int n;
		n = 0;
		while (x != 0) begin
			n++;
			x = x >> 1;
		end
		return n;
	endfunction

	// accept one vertex; on the third of a triangle queue the expected tangent
	task automatic predict_tangent(input vertex_t v);
		longint s0[3], s1[3], t[3], p[3], nrm[3];
		longint du0, du1, dv0, dv1, det, u, w;
		longint unsigned a[3], sum, r, q;
		bit mir, ng;
		int len, l;
		tangent_t res;
		p[0] = v.px;
		p[1] = v.py;
		p[2] = v.pz;
		u = v.tu;
		w = v.tv;
		if (vtx_count < 2) begin
			for (int i = 0; i < 3; i++) held_pos[vtx_count * 3 + i] = p[i];
			held_tex[vtx_count * 2] = u;
			held_tex[vtx_count * 2 + 1] = w;
			vtx_count++;
		end else begin
			vtx_count = 0;
			du0 = held_tex[0] - held_tex[2];
			du1 = u - held_tex[0];
			dv0 = held_tex[1] - held_tex[3];
			dv1 = w - held_tex[1];
			for (int i = 0; i < 3; i++) begin
				s0[i] = held_pos[i] - held_pos[3 + i];
				s1[i] = p[i] - held_pos[i];
				t[i] = dv1 * s0[i] - dv0 * s1[i];
			end
			nrm[0] = s1[1] * s0[2] - s1[2] * s0[1];
			nrm[1] = s1[2] * s0[0] - s1[0] * s0[2];
			nrm[2] = s1[0] * s0[1] - s1[1] * s0[0];
			det = dv1 * du0 - dv0 * du1;
			// mirrored only with a nonzero normal and negative uv determinant
			mir = (nrm[0] != 0 || nrm[1] != 0 || nrm[2] != 0) && det < 0;
			len = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = (t[i] < 0) ? -t[i] : t[i];
				l = bit_length(a[i]);
				if (l > len) len = l;
			end
			if (len == 0) begin
				res = '{tx: '0, ty: '0, tz: '0, mir: 1'b0, degen: 1'b1};
			end else begin
				// common power-of-two scale puts the largest in [2^29, 2^30)
				sum = 0;
				for (int i = 0; i < 3; i++) begin
					a[i] = (len > 30) ? (a[i] >> (len - 30)) : (a[i] << (30 - len));
					sum += a[i] * a[i];
				end
				r = int_sqrt(sum);
				res.mir = mir;
				res.degen = 1'b0;
				for (int i = 0; i < 3; i++) begin
					q = (a[i] * 16384 + (r >> 1)) / r;
					ng = (t[i] < 0) != mir;
					q = ng ? -q : q;
					if (i == 0) res.tx = q[OUT_W-1:0];
					else if (i == 1) res.ty = q[OUT_W-1:0];
					else res.tz = q[OUT_W-1:0];
				end
			end
			tangent_fifo.push_back(res);
		end
	endtask

	// input side: hold the request until accepted, then maybe idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (!in_valid || in_ready) begin
				if (in_valid)
					predict_tangent('{px: pos_x, py: pos_y, pz: pos_z, tu: tex_u, tv: tex_v});
				if (stop_send || vertex_fifo.size() == 0 ||
						$urandom_range(99) < send_idle) begin
					in_valid <= 1'b0;
				end else begin
					vertex_t nv;
					nv = vertex_fifo.pop_front();
					pos_x <= nv.px;
					pos_y <= nv.py;
					pos_z <= nv.pz;
					tex_u <= nv.tu;
					tex_v <= nv.tv;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// output side: compare each accepted tangent with the oldest expected one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (tangent_fifo.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected tangent %0d %0d %0d m=%0b d=%0b",
							tan_x, tan_y, tan_z, mirrored, degenerate);
				end else begin
					tangent_t e;
					e = tangent_fifo.pop_front();
					if (e.tx !== tan_x || e.ty !== tan_y || e.tz !== tan_z ||
							e.mir !== mirrored || e.degen !== degenerate) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp %0d %0d %0d m=%0b d=%0b got %0d %0d %0d m=%0b d=%0b",
								$signed(e.tx), $signed(e.ty), $signed(e.tz), e.mir, e.degen,
								tan_x, tan_y, tan_z, mirrored, degenerate);
					end
				end
			end
			// long back-pressure stretch, counted here
			if (hold_request && !hold_started) begin
				hold_started = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_vertex(input int x, y, z, u, v);
		vertex_fifo.push_back('{px: x[15:0], py: y[15:0], pz: z[15:0], tu: u[15:0], tv: v[15:0]});
	endtask

	function automatic int rnd16();
		return $urandom_range(65535) - 32768;
	endfunction

	// random triangle: full range, repeated texcoords, or a small one near a random anchor
	task automatic push_random_triangle();
		int kind, bx, by, bz, bu, bv, sp;
		kind = $urandom_range(9);
		bx = rnd16() / 2; by = rnd16() / 2; bz = rnd16() / 2;
		bu = rnd16() / 2; bv = rnd16() / 2;
		sp = 1 << $urandom_range(14);
		for (int k = 0; k < 3; k++) begin
			if (kind < 4)
				push_vertex(rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
			else if (kind == 4)
				// repeated texcoords give a zero tangent
				push_vertex(rnd16(), rnd16(), rnd16(), bu, bv);
			else
				push_vertex(bx + $urandom_range(sp) - sp / 2, by + $urandom_range(sp) - sp / 2,
					bz + $urandom_range(sp) - sp / 2, bu + $urandom_range(sp) - sp / 2,
					bv + $urandom_range(sp) - sp / 2);
		end
	endtask

	// wait until every vertex is sent and every expected tangent has come back
	task automatic drain();
		while (vertex_fifo.size() != 0 || in_valid || tangent_fifo.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes of every field
		push_vertex(-32768, -32768, -32768, -32768, -32768);
		push_vertex(32767, 32767, 32767, 32767, 32767);
		push_vertex(-32768, 32767, -32768, 32767, -32768);
		push_vertex(32767, -32768, 32767, -32768, 32767);
		push_vertex(-32768, -32768, 32767, 32767, -32768);
		push_vertex(0, 32767, -32768, -32768, 32767);
		// all vertices equal: zero tangent
		repeat (3) push_vertex(256, -512, 1024, 4096, 4096);
		// collinear positions: zero normal, tangent still defined
		push_vertex(0, 0, 0, 0, 0);
		push_vertex(256, 256, 256, 4096, 0);
		push_vertex(512, 512, 512, 0, 4096);
		// plain right triangle, mirrored
		push_vertex(0, 0, 0, 0, 0);
		push_vertex(256, 0, 0, 4096, 0);
		push_vertex(0, 256, 0, 0, 4096);
		// same with v flipped: not mirrored
		push_vertex(0, 0, 0, 0, 0);
		push_vertex(256, 0, 0, 4096, 0);
		push_vertex(0, 256, 0, 0, -4096);
		// collinear texcoords: zero determinant
		push_vertex(0, 0, 0, 0, 0);
		push_vertex(256, 0, 0, 4096, 4096);
		push_vertex(0, 256, 0, 8192, 8192);
		repeat (210) push_random_triangle();
		drain();

		send_idle = 85;
		recv_idle = 7;
		repeat (220) push_random_triangle();
		drain();

		// no idling, with one long receiver hold while the sender keeps offering
		send_idle = 0;
		recv_idle = 0;
		hold_request = 1'b1;
		repeat (220) push_random_triangle();
		drain();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
